/* rtl/pjhc_pkg.sv */
`default_nettype none
package pjhc_pkg;
  localparam logic [31:0] CrcPoly   = 32'hedb88320;
  localparam logic [31:0] CrcInit   = 32'hffffffff;
  localparam logic [31:0] TypeIhdr  = 32'h49484452;
  localparam logic [31:0] TypeIdat  = 32'h49444154;
  localparam logic [31:0] TypeIend  = 32'h49454e44;
  localparam logic [31:0] IhdrLen   = 32'd13;
  localparam logic [15:0] SofMinLen = 16'd7;

  localparam logic [2:0] PngSig  = 3'd0;
  localparam logic [2:0] PngLen  = 3'd1;
  localparam logic [2:0] PngType = 3'd2;
  localparam logic [2:0] PngData = 3'd3;
  localparam logic [2:0] PngCrc  = 3'd4;
  localparam logic [2:0] PngDone = 3'd5;

  localparam logic [2:0] JpS0   = 3'd0;
  localparam logic [2:0] JpS1   = 3'd1;
  localparam logic [2:0] JpMark = 3'd2;
  localparam logic [2:0] JpLhi  = 3'd3;
  localparam logic [2:0] JpLlo  = 3'd4;
  localparam logic [2:0] JpBody = 3'd5;
  localparam logic [2:0] JpDone = 3'd6;

  typedef enum logic [1:0] {
    FmtNone = 2'd0,
    FmtPng  = 2'd1,
    FmtJpeg = 2'd2
  } fmt_e;

  // per-parser verdict handed to the top level
  typedef struct packed {
    logic        ok;
    logic [30:0] width;
    logic [30:0] height;
  } verdict_t;

  function automatic logic [7:0] png_sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0: r = 8'h89;
      3'd1: r = 8'h50;
      3'd2: r = 8'h4e;
      3'd3: r = 8'h47;
      3'd4: r = 8'h0d;
      3'd5: r = 8'h0a;
      3'd6: r = 8'h1a;
      default: r = 8'h0a;
    endcase
    return r;
  endfunction

  // one byte through the reflected CRC-32, eight bit steps
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

  function automatic logic is_sof(input logic [7:0] m);
    return (m[7:4] == 4'hc) && (m != 8'hc4) && (m != 8'hc8) && (m != 8'hcc);
  endfunction
endpackage
`default_nettype wire

/* rtl/pjhc_png.sv */
`default_nettype none
module pjhc_png (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              last_i,
  input  wire logic [7:0]        data_i,
  output pjhc_pkg::verdict_t     verdict_o
);
  import pjhc_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [2:0]  idx_q, idx_d;
  logic [31:0] len_q, len_d, left_q, left_d, crc_q, crc_d, type_q, type_d;
  logic [63:0] size_q, size_d;
  logic        hdr_q, hdr_d, idat_q, idat_d, bad_q, bad_d;
  logic [31:0] crc_nx, type_nx, fin;
  logic [7:0]  crc_b;
  logic [63:0] size_nx;

  assign crc_nx  = crc_byte(crc_q, data_i);
  assign type_nx = {type_q[23:0], data_i};
  assign size_nx = {size_q[55:0], data_i};
  assign fin     = ~crc_q;

  always_comb begin
    unique case (idx_q[1:0])
      2'd0: crc_b = fin[31:24];
      2'd1: crc_b = fin[23:16];
      2'd2: crc_b = fin[15:8];
      default: crc_b = fin[7:0];
    endcase
  end

  // next state for one byte
  always_comb begin
    phase_d = phase_q; idx_d = idx_q; len_d = len_q; left_d = left_q;
    crc_d = crc_q; type_d = type_q; size_d = size_q;
    hdr_d = hdr_q; idat_d = idat_q; bad_d = bad_q;
    if (!bad_q) begin
      unique case (phase_q)
        PngSig: begin
          if (data_i != png_sig_byte(idx_q)) bad_d = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            idx_d = '0; len_d = '0; phase_d = PngLen;
          end
        end
        PngLen: begin
          len_d = {len_q[23:0], data_i};
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = '0; type_d = '0; crc_d = CrcInit; phase_d = PngType;
          end
        end
        PngType: begin
          crc_d = crc_nx; type_d = type_nx;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = '0;
            if (!hdr_q) begin
              if (type_nx != TypeIhdr || len_q != IhdrLen) bad_d = 1'b1;
              else hdr_d = 1'b1;
            end else if (type_nx == TypeIhdr) begin
              bad_d = 1'b1;
            end
            if (type_nx == TypeIdat) idat_d = 1'b1;
            if (type_nx == TypeIend && (len_q != '0 || !(idat_q || type_nx == TypeIdat)))
              bad_d = 1'b1;
            left_d = len_q;
            phase_d = (len_q != '0) ? PngData : PngCrc;
          end
        end
        PngData: begin
          crc_d = crc_nx;
          if (type_q == TypeIhdr && left_q > 32'd5) size_d = size_nx;
          left_d = left_q - 32'd1;
          if (left_q == 32'd1) begin
            if (type_q == TypeIhdr) begin
              if (size_d[63:32] == '0 || size_d[31:0] == '0 ||
                  size_d[63] || size_d[31]) bad_d = 1'b1;
            end
            phase_d = PngCrc;
          end
        end
        PngCrc: begin
          if (crc_b != data_i) bad_d = 1'b1;
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd3) begin
            idx_d = '0;
            if (type_q == TypeIend) phase_d = PngDone;
            else begin
              len_d = '0; phase_d = PngLen;
            end
          end
        end
        default: bad_d = 1'b1;
      endcase
    end
  end

  assign verdict_o.ok     = !bad_d && phase_d == PngDone;
  assign verdict_o.width  = size_d[62:32];
  assign verdict_o.height = size_d[30:0];

  // state registers; the last byte returns everything to reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PngSig; idx_q <= '0; len_q <= '0; left_q <= '0;
      crc_q <= CrcInit; type_q <= '0; size_q <= '0;
      hdr_q <= 1'b0; idat_q <= 1'b0; bad_q <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= PngSig; idx_q <= '0; len_q <= '0; left_q <= '0;
        crc_q <= CrcInit; type_q <= '0; size_q <= '0;
        hdr_q <= 1'b0; idat_q <= 1'b0; bad_q <= 1'b0;
      end else begin
        phase_q <= phase_d; idx_q <= idx_d; len_q <= len_d; left_q <= left_d;
        crc_q <= crc_d; type_q <= type_d; size_q <= size_d;
        hdr_q <= hdr_d; idat_q <= idat_d; bad_q <= bad_d;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/pjhc_jpeg.sv */
`default_nettype none
module pjhc_jpeg (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic              last_i,
  input  wire logic [7:0]        data_i,
  output pjhc_pkg::verdict_t     verdict_o
);
  import pjhc_pkg::*;

  logic [2:0]  phase_q, phase_d;
  logic [7:0]  mark_q, mark_d;
  logic [15:0] left_q, left_d;
  logic [31:0] size_q, size_d;
  logic [2:0]  bidx_q, bidx_d;
  logic        found_q, found_d, bad_q, bad_d;
  logic [15:0] recent_q;
  logic [1:0]  cnt_q;
  logic [15:0] seg_len;
  logic        sof;

  assign sof     = is_sof(mark_q);
  assign seg_len = {left_q[15:8], data_i};

  // next state for one byte
  always_comb begin
    phase_d = phase_q; mark_d = mark_q; left_d = left_q; size_d = size_q;
    bidx_d = bidx_q; found_d = found_q; bad_d = bad_q;
    if (!bad_q) begin
      unique case (phase_q)
        JpS0: begin
          if (data_i != 8'hff) bad_d = 1'b1;
          phase_d = JpS1;
        end
        JpS1: begin
          if (data_i != 8'hd8) bad_d = 1'b1;
          phase_d = JpMark;
        end
        JpMark: begin
          if (data_i == 8'hff || data_i == 8'h00 || data_i == 8'hd8 ||
              data_i == 8'h01 || data_i[7:3] == 5'b11010) begin
            phase_d = JpMark;
          end else if (data_i == 8'hd9 || data_i == 8'hda) begin
            bad_d = 1'b1;
          end else begin
            mark_d = data_i; phase_d = JpLhi;
          end
        end
        JpLhi: begin
          left_d = {data_i, 8'd0}; phase_d = JpLlo;
        end
        JpLlo: begin
          if (seg_len < 16'd2 || (sof && seg_len < SofMinLen)) begin
            bad_d = 1'b1;
          end else begin
            left_d = seg_len - 16'd2; bidx_d = '0; size_d = '0;
            phase_d = (seg_len != 16'd2) ? JpBody : JpMark;
          end
        end
        JpBody: begin
          if (sof && bidx_q >= 3'd1 && bidx_q <= 3'd4) size_d = {size_q[23:0], data_i};
          if (bidx_q != 3'd7) bidx_d = bidx_q + 3'd1;
          left_d = left_q - 16'd1;
          if (left_q == 16'd1) begin
            if (sof) begin
              if (size_d[31:16] == '0 || size_d[15:0] == '0) bad_d = 1'b1;
              else begin
                found_d = 1'b1; phase_d = JpDone;
              end
            end else phase_d = JpMark;
          end
        end
        JpDone: phase_d = JpDone;
        default: bad_d = 1'b1;
      endcase
    end
  end

  // byte count needs only to reach four; it saturates at three before this byte
  assign verdict_o.ok     = !bad_d && found_d && cnt_q == 2'd3 &&
                            recent_q[7:0] == 8'hff && data_i == 8'hd9;
  assign verdict_o.width  = {15'd0, size_d[15:0]};
  assign verdict_o.height = {15'd0, size_d[31:16]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= JpS0; mark_q <= '0; left_q <= '0; size_q <= '0; bidx_q <= '0;
      found_q <= 1'b0; bad_q <= 1'b0; recent_q <= '0; cnt_q <= '0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= JpS0; mark_q <= '0; left_q <= '0; size_q <= '0; bidx_q <= '0;
        found_q <= 1'b0; bad_q <= 1'b0; recent_q <= '0; cnt_q <= '0;
      end else begin
        phase_q <= phase_d; mark_q <= mark_d; left_q <= left_d; size_q <= size_d;
        bidx_q <= bidx_d; found_q <= found_d; bad_q <= bad_d;
        recent_q <= {recent_q[7:0], data_i};
        if (cnt_q != 2'd3) cnt_q <= cnt_q + 2'd1;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/png_jpeg_image_header_checker.sv */
`default_nettype none
// channel | handshake         | payload
// in      | in_valid/in_ready | data_byte_i, last_byte_i
// out     | out_valid/out_ready | image_ok_o, image_format_o, image_width_o, image_height_o
// One byte is taken per cycle while in_ready is high; both parsers update in the accept cycle.
// The result word is registered on the last byte and shows in the next cycle.
// in_ready is low only while a result word waits and out_ready is low.
// Reset (rst_ni low, async) clears both parsers to the start of a file.
module png_jpeg_image_header_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_byte_i,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             image_ok_o,
  output logic [1:0]       image_format_o,
  output logic [30:0]      image_width_o,
  output logic [30:0]      image_height_o
);
  import pjhc_pkg::*;

  logic        step;
  verdict_t    png_v, jpg_v;
  logic        out_valid_q;
  logic        ok_q;
  logic [1:0]  fmt_q;
  logic [30:0] width_q, height_q;

  assign in_ready = !out_valid_q || out_ready;
  assign step     = in_valid && in_ready;

  assign out_valid      = out_valid_q;
  assign image_ok_o     = ok_q;
  assign image_format_o = fmt_q;
  assign image_width_o  = width_q;
  assign image_height_o = height_q;

  pjhc_png u_png (.clk_i, .rst_ni, .step_i(step), .last_i(last_byte_i),
                  .data_i(data_byte_i), .verdict_o(png_v));
  pjhc_jpeg u_jpeg (.clk_i, .rst_ni, .step_i(step), .last_i(last_byte_i),
                    .data_i(data_byte_i), .verdict_o(jpg_v));

  // result register; PNG wins over JPEG
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && last_byte_i) begin
      if (png_v.ok) begin
        ok_q <= 1'b1; fmt_q <= FmtPng;
        width_q <= png_v.width; height_q <= png_v.height;
      end else if (jpg_v.ok) begin
        ok_q <= 1'b1; fmt_q <= FmtJpeg;
        width_q <= jpg_v.width; height_q <= jpg_v.height;
      end else begin
        ok_q <= 1'b0; fmt_q <= FmtNone;
        width_q <= '0; height_q <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* sim/png_jpeg_image_header_checker_mon.sv */
`timescale 1ns / 100ps
module png_jpeg_image_header_checker_mon (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        image_ok_i,
  input  logic [1:0]  image_format_i,
  input  logic [30:0] image_width_i,
  input  logic [30:0] image_height_i,
  output int          fail_count_o,
  output int          pending_o
);
  import pjhc_pkg::*;

  typedef struct packed {
    logic        ok;
    fmt_e        fmt;
    logic [30:0] width;
    logic [30:0] height;
  } verdict_word_t;

  localparam logic [7:0] SigBytes [8] = '{8'h89, 8'h50, 8'h4e, 8'h47,
                                          8'h0d, 8'h0a, 8'h1a, 8'h0a};

  verdict_word_t verdict_q[$];

  // parser state mirrored from the block
  logic [31:0] bytes_seen;
  logic [2:0]  png_state;
  logic [3:0]  png_idx;
  logic [31:0] chunk_len, chunk_left, chunk_crc, chunk_type;
  logic        saw_ihdr, saw_idat, saw_iend, png_bad;
  logic [63:0] png_dims;
  logic [2:0]  jpg_state;
  logic [7:0]  jpg_marker;
  logic [15:0] seg_left, seg_idx;
  logic        jpg_found, jpg_bad;
  logic [31:0] jpg_dims;
  logic [15:0] tail_bytes;

  function automatic logic [31:0] crc_next(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  function automatic logic sof_marker(input logic [7:0] m);
    return m >= 8'hc0 && m <= 8'hcf && m != 8'hc4 && m != 8'hc8 && m != 8'hcc;
  endfunction

  task automatic clear_parsers();
    bytes_seen = '0; png_state = PngSig; png_idx = '0;
    chunk_len = '0; chunk_left = '0; chunk_crc = CrcInit; chunk_type = '0;
    saw_ihdr = 0; saw_idat = 0; saw_iend = 0; png_bad = 0; png_dims = '0;
    jpg_state = JpS0; jpg_marker = '0; seg_left = '0; seg_idx = '0;
    jpg_found = 0; jpg_bad = 0; jpg_dims = '0; tail_bytes = '0;
  endtask

  task automatic png_take(input logic [7:0] b);
    logic [31:0] fin;
    if (png_bad) return;
    case (png_state)
      PngSig: begin
        if (b != SigBytes[png_idx[2:0]]) png_bad = 1;
        png_idx++;
        if (png_idx >= 8) begin
          png_idx = 0; chunk_len = 0; png_state = PngLen;
        end
      end
      PngLen: begin
        chunk_len = {chunk_len[23:0], b};
        png_idx++;
        if (png_idx >= 4) begin
          png_idx = 0; chunk_type = 0; chunk_crc = CrcInit; png_state = PngType;
        end
      end
      PngType: begin
        chunk_crc = crc_next(chunk_crc, b);
        chunk_type = {chunk_type[23:0], b};
        png_idx++;
        if (png_idx >= 4) begin
          png_idx = 0;
          // chunk order rules
          if (!saw_ihdr) begin
            if (chunk_type != TypeIhdr || chunk_len != IhdrLen) png_bad = 1;
            else saw_ihdr = 1;
          end else if (chunk_type == TypeIhdr) begin
            png_bad = 1;
          end
          if (chunk_type == TypeIdat) saw_idat = 1;
          if (chunk_type == TypeIend && (chunk_len != 0 || !saw_idat)) png_bad = 1;
          chunk_left = chunk_len;
          png_state = (chunk_len != 0) ? PngData : PngCrc;
        end
      end
      PngData: begin
        chunk_crc = crc_next(chunk_crc, b);
        if (chunk_type == TypeIhdr && chunk_left > 5) png_dims = {png_dims[55:0], b};
        chunk_left--;
        if (chunk_left == 0) begin
          if (chunk_type == TypeIhdr &&
              (png_dims[63:32] == 0 || png_dims[31:0] == 0 || png_dims[63] || png_dims[31]))
            png_bad = 1;
          png_state = PngCrc;
        end
      end
      PngCrc: begin
        fin = ~chunk_crc;
        if (8'(fin >> (24 - 8 * png_idx[1:0])) != b) png_bad = 1;
        png_idx++;
        if (png_idx >= 4) begin
          png_idx = 0;
          if (chunk_type == TypeIend) begin
            saw_iend = 1; png_state = PngDone;
          end else begin
            chunk_len = 0; png_state = PngLen;
          end
        end
      end
      default: png_bad = 1;
    endcase
  endtask

  task automatic jpg_take(input logic [7:0] b);
    logic [15:0] len;
    if (jpg_bad) return;
    case (jpg_state)
      JpS0: begin
        if (b != 8'hff) jpg_bad = 1;
        jpg_state = JpS1;
      end
      JpS1: begin
        if (b != 8'hd8) jpg_bad = 1;
        jpg_state = JpMark;
      end
      JpMark: begin
        // fill bytes and standalone markers are skipped
        if (b == 8'hff || b == 8'h00 || b == 8'hd8 || b == 8'h01 ||
            (b >= 8'hd0 && b <= 8'hd7)) begin
        end else if (b == 8'hd9 || b == 8'hda) begin
          jpg_bad = 1;
        end else begin
          jpg_marker = b; jpg_state = JpLhi;
        end
      end
      JpLhi: begin
        seg_left = {b, 8'h00}; jpg_state = JpLlo;
      end
      JpLlo: begin
        len = {seg_left[15:8], b};
        if (len < 2 || (sof_marker(jpg_marker) && len < SofMinLen)) begin
          jpg_bad = 1;
        end else begin
          seg_left = len - 2; seg_idx = 0; jpg_dims = 0;
          jpg_state = (seg_left != 0) ? JpBody : JpMark;
        end
      end
      JpBody: begin
        if (sof_marker(jpg_marker) && seg_idx >= 1 && seg_idx <= 4)
          jpg_dims = {jpg_dims[23:0], b};
        if (seg_idx != 16'hffff) seg_idx++;
        seg_left--;
        if (seg_left == 0) begin
          if (sof_marker(jpg_marker)) begin
            if (jpg_dims[31:16] == 0 || jpg_dims[15:0] == 0) jpg_bad = 1;
            else begin
              jpg_found = 1; jpg_state = JpDone;
            end
          end else begin
            jpg_state = JpMark;
          end
        end
      end
      JpDone: ;
      default: jpg_bad = 1;
    endcase
  endtask

  // advance both parsers by one word; a last word yields the verdict
  task automatic take_byte(input logic [7:0] b, input logic last);
    verdict_word_t v;
    if (bytes_seen != 32'hffffffff) bytes_seen++;
    tail_bytes = {tail_bytes[7:0], b};
    png_take(b);
    jpg_take(b);
    if (!last) return;
    v = '{ok: 1'b0, fmt: FmtNone, width: '0, height: '0};
    if (!png_bad && png_state == PngDone) begin
      v = '{ok: 1'b1, fmt: FmtPng, width: png_dims[62:32], height: png_dims[30:0]};
    end else if (!jpg_bad && jpg_found && bytes_seen >= 4 && tail_bytes == 16'hffd9) begin
      v = '{ok: 1'b1, fmt: FmtJpeg, width: {15'd0, jpg_dims[15:0]},
            height: {15'd0, jpg_dims[31:16]}};
    end
    verdict_q.push_back(v);
    clear_parsers();
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    clear_parsers();
  end

  assign pending_o = verdict_q.size();

  always @(posedge clk_i) begin
    verdict_word_t w;
    if (rst_ni) begin
      // result words first, then the new input word
      if (out_valid_i && out_ready_i) begin
        if (verdict_q.size() == 0) begin
          report("unexpected result word", 0, 0);
        end else begin
          w = verdict_q.pop_front();
          if (image_ok_i !== w.ok) report("image_ok", image_ok_i, w.ok);
          if (image_format_i !== w.fmt) report("image_format", image_format_i, w.fmt);
          if (image_width_i !== w.width) report("image_width", image_width_i, w.width);
          if (image_height_i !== w.height) report("image_height", image_height_i, w.height);
        end
      end
      if (in_valid_i && in_ready_i) take_byte(data_byte_i, last_byte_i);
    end
  end

endmodule

/* sim/tb_png_jpeg_image_header_checker.sv */
`timescale 1ns / 100ps
module tb_png_jpeg_image_header_checker;
  import pjhc_pkg::*;

  localparam int HoldCycles = 300;
  localparam int IdleLimit  = 2000;

  logic        clk_i, rst_ni;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [7:0]  data_byte_i;
  logic        last_byte_i;
  logic        image_ok_o;
  logic [1:0]  image_format_o;
  logic [30:0] image_width_o, image_height_o;
  int          fail_count, pending;

  logic [7:0]  file_q[$];
  int          burst_left;
  int          bytes_sent;
  int          idle_cycles;
  logic        hold_req, hold_done;

  png_jpeg_image_header_checker dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .data_byte_i, .last_byte_i,
    .out_valid, .out_ready, .image_ok_o, .image_format_o, .image_width_o, .image_height_o
  );

  png_jpeg_image_header_checker_mon mon (
    .clk_i, .rst_ni, .in_valid_i(in_valid), .in_ready_i(in_ready),
    .data_byte_i, .last_byte_i, .out_valid_i(out_valid), .out_ready_i(out_ready),
    .image_ok_i(image_ok_o), .image_format_i(image_format_o),
    .image_width_i(image_width_o), .image_height_i(image_height_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1; #1;
    clk_i = 1'b0; #1;
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("png_jpeg_image_header_checker regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: changing ready pattern plus one long hold-off
  initial begin
    int mode, cnt;
    out_ready = 1'b0;
    hold_done = 1'b0;
    mode = 0;
    cnt = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      if (cnt == 0) begin
        mode = $urandom_range(0, 3);
        cnt = $urandom_range(16, 96);
      end
      cnt--;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom_range(0, 1));
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= (cnt % 8) < 5;
      endcase
    end
  end

  function automatic logic [31:0] crc_upd(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    return c;
  endfunction

  task automatic put_be32(input logic [31:0] v);
    for (int i = 3; i >= 0; i--) file_q.push_back(v[8*i +: 8]);
  endtask

  // chunk with length, type, body and a good CRC
  task automatic put_chunk(input logic [31:0] ctype, input logic [7:0] body[$]);
    logic [31:0] c;
    c = CrcInit;
    put_be32(body.size());
    put_be32(ctype);
    for (int i = 3; i >= 0; i--) c = crc_upd(c, ctype[8*i +: 8]);
    foreach (body[i]) begin
      file_q.push_back(body[i]);
      c = crc_upd(c, body[i]);
    end
    put_be32(~c);
  endtask

  task automatic put_ihdr(input logic [31:0] w, input logic [31:0] h);
    logic [7:0] body[$];
    for (int i = 3; i >= 0; i--) body.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) body.push_back(h[8*i +: 8]);
    body.push_back(8'd8);
    body.push_back(8'($urandom_range(0, 6)));
    repeat (3) body.push_back(8'd0);
    put_chunk(TypeIhdr, body);
  endtask

  task automatic put_rand_chunk(input logic [31:0] ctype, input int len);
    logic [7:0] body[$];
    repeat (len) body.push_back(8'($urandom));
    put_chunk(ctype, body);
  endtask

  task automatic put_sig();
    file_q.push_back(8'h89); file_q.push_back(8'h50);
    file_q.push_back(8'h4e); file_q.push_back(8'h47);
    file_q.push_back(8'h0d); file_q.push_back(8'h0a);
    file_q.push_back(8'h1a); file_q.push_back(8'h0a);
  endtask

  task automatic build_png(input logic [31:0] w, input logic [31:0] h);
    put_sig();
    put_ihdr(w, h);
    if ($urandom_range(0, 2) == 0) put_rand_chunk(32'h74455874, $urandom_range(0, 5));
    repeat ($urandom_range(1, 2)) put_rand_chunk(TypeIdat, $urandom_range(0, 6));
    put_rand_chunk(TypeIend, 0);
  endtask

  task automatic put_segment(input logic [7:0] marker, input int len);
    file_q.push_back(8'hff);
    file_q.push_back(marker);
    file_q.push_back(8'(len >> 8));
    file_q.push_back(8'(len));
    repeat (len - 2) file_q.push_back(8'($urandom));
  endtask

  task automatic put_sof(input logic [7:0] marker, input logic [15:0] h, input logic [15:0] w,
                         input int len);
    file_q.push_back(8'hff);
    file_q.push_back(marker);
    file_q.push_back(8'(len >> 8));
    file_q.push_back(8'(len));
    file_q.push_back(8'd8);
    file_q.push_back(h[15:8]); file_q.push_back(h[7:0]);
    file_q.push_back(w[15:8]); file_q.push_back(w[7:0]);
    repeat (len - 7) file_q.push_back(8'($urandom));
  endtask

  task automatic build_jpeg(input logic [15:0] h, input logic [15:0] w);
    logic [7:0] sofs[12] = '{8'hc0, 8'hc1, 8'hc2, 8'hc3, 8'hc5, 8'hc6, 8'hc7,
                             8'hc9, 8'hca, 8'hcb, 8'hcd, 8'hcf};
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    repeat ($urandom_range(0, 2)) file_q.push_back(8'hff);
    if ($urandom_range(0, 1)) file_q.push_back(8'hd0 + 8'($urandom_range(0, 7)));
    if ($urandom_range(0, 1)) file_q.push_back(8'h01);
    if ($urandom_range(0, 1))
      put_segment(8'he0 + 8'($urandom_range(0, 15)), $urandom_range(2, 6));
    if ($urandom_range(0, 3) == 0) put_segment(8'hc4, $urandom_range(2, 5));
    put_sof(sofs[$urandom_range(0, 11)], h, w, $urandom_range(7, 10));
    repeat ($urandom_range(0, 5)) file_q.push_back(8'($urandom));
    file_q.push_back(8'hff); file_q.push_back(8'hd9);
  endtask

  // damage a built file: bit flip, truncation or extra word
  task automatic mangle();
    int idx;
    case ($urandom_range(0, 2))
      0: begin
        idx = $urandom_range(0, file_q.size() - 1);
        file_q[idx] = file_q[idx] ^ (8'h01 << $urandom_range(0, 7));
      end
      1: if (file_q.size() > 1) void'(file_q.pop_back());
      default: file_q.push_back(8'($urandom));
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_file();
    foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
    file_q.delete();
  endtask

  initial begin
    int kind, files;
    in_valid = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    hold_req = 1'b0;
    burst_left = 0;
    bytes_sent = 0;
    rst_ni = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed files
    file_q.push_back(8'h00); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    file_q.push_back(8'hff); file_q.push_back(8'hd9); send_file();
    build_jpeg(16'hffff, 16'hffff); send_file();
    build_jpeg(16'd1, 16'd1); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    put_sof(8'hc0, 16'd10, 16'd10, 7); file_q[5] = 8'd6;
    file_q.push_back(8'hff); file_q.push_back(8'hd9); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    put_sof(8'hc0, 16'd5, 16'd0, 8);
    file_q.push_back(8'hff); file_q.push_back(8'hd9); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    put_segment(8'hda, 4); file_q.push_back(8'hff); file_q.push_back(8'hd9); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    file_q.push_back(8'hff); file_q.push_back(8'hd9); file_q.push_back(8'hff);
    file_q.push_back(8'hd9); send_file();
    file_q.push_back(8'hff); file_q.push_back(8'hd8);
    put_segment(8'he1, 20); void'(file_q.pop_back()); send_file();
    build_png(32'h7fffffff, 32'h7fffffff); send_file();
    build_png(32'd1, 32'd1); send_file();
    build_png(32'h80000000, 32'd4); send_file();
    build_png(32'd0, 32'd4); send_file();
    build_png(32'd4, 32'hffffffff); send_file();
    put_sig(); put_ihdr(32'd3, 32'd3); put_rand_chunk(TypeIend, 0); send_file();
    put_sig(); put_ihdr(32'd3, 32'd3); put_rand_chunk(TypeIdat, 2);
    put_rand_chunk(TypeIend, 1); send_file();
    put_sig(); put_ihdr(32'd3, 32'd3); put_ihdr(32'd3, 32'd3);
    put_rand_chunk(TypeIdat, 2); put_rand_chunk(TypeIend, 0); send_file();
    build_png(32'd9, 32'd7); file_q.push_back(8'h00); send_file();
    build_png(32'd9, 32'd7); file_q[file_q.size() - 1] ^= 8'h80; send_file();

    // random files, mostly well formed
    files = 0;
    while (bytes_sent < 1300 || files < 10) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        build_png($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000),
                  $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 5000));
      end else if (kind < 80) begin
        build_jpeg($urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 65535)),
                   $urandom_range(0, 9) == 0 ? 16'd0 : 16'($urandom_range(1, 65535)));
      end else begin
        if ($urandom_range(0, 1)) put_sig();
        else if ($urandom_range(0, 1)) begin
          file_q.push_back(8'hff); file_q.push_back(8'hd8);
        end
        repeat ($urandom_range(1, 20)) file_q.push_back(8'($urandom));
      end
      if (kind < 80 && $urandom_range(0, 3) == 0) mangle();
      send_file();
      files++;
      if (files == 3) hold_req = 1'b1;
      if (files == 8) begin
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk_i);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("png_jpeg_image_header_checker regression: pass");
    end else begin
      $display("png_jpeg_image_header_checker regression: fail");
    end
    $finish;
  end

endmodule

/* png_jpeg_image_header_checker.f */
rtl/pjhc_pkg.sv
rtl/pjhc_png.sv
rtl/pjhc_jpeg.sv
rtl/png_jpeg_image_header_checker.sv
sim/png_jpeg_image_header_checker_mon.sv
sim/tb_png_jpeg_image_header_checker.sv
